// ----- hdl/afd_pkg.sv -----
// Shared types, constants and helpers for the accelerometer fall detector.
// No dependencies; every other file of the block imports this package.
package afd_pkg;

  localparam int MagWidth   = 16;
  localparam int CountWidth = 15;
  localparam int WinWidth   = 14;
  localparam int AddrWidth  = 5;
  localparam int DataWidth  = 32;

  // Queue between front and back; depth must be a power of two.
  localparam int QueueDepth = 2;
  localparam int PtrWidth   = $clog2(QueueDepth);

  typedef logic [MagWidth-1:0]   mag_t;
  typedef logic [CountWidth-1:0] cnt_t;
  typedef logic [WinWidth-1:0]   win_t;

  localparam mag_t OneG      = mag_t'(4096);
  localparam mag_t StillBand = mag_t'(1228);
  localparam mag_t StillLo   = OneG - StillBand;
  localparam mag_t StillHi   = OneG + StillBand;
  localparam cnt_t CountMax  = '1;

  typedef enum logic [2:0] {
    REG_FF_THR    = 3'd0,
    REG_IMP_THR   = 3'd1,
    REG_FF_MIN    = 3'd2,
    REG_IMP_WIN   = 3'd3,
    REG_STILL_MIN = 3'd4,
    REG_POST_MAX  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    mag_t ff_thr;
    mag_t imp_thr;
    win_t ff_min;
    win_t imp_win;
    win_t still_need;
    win_t post_lim;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    ff_thr:     mag_t'(1434),
    imp_thr:    mag_t'(10240),
    ff_min:     win_t'(4),
    imp_win:    win_t'(15),
    still_need: win_t'(50),
    post_lim:   win_t'(150)
  };

  // Sample after classification by the front end.
  typedef struct packed {
    logic below_ff;
    logic above_imp;
    logic still;
    mag_t mag;
  } sample_t;

  typedef enum logic [3:0] {
    PH_NORMAL   = 4'b0001,
    PH_FREEFALL = 4'b0010,
    PH_WAIT     = 4'b0100,
    PH_POST     = 4'b1000
  } phase_e;

  function automatic cnt_t sat_inc(cnt_t c);
    return (c == CountMax) ? c : c + cnt_t'(1);
  endfunction

endpackage

// ----- hdl/afd_if.sv -----
// Valid/ready stream interfaces for the fall detector's sample and result channels.
// Depends on afd_pkg.
interface afd_in_if import afd_pkg::*; ();
  logic valid;
  logic ready;
  mag_t accel_magnitude;

  modport source (output valid, output accel_magnitude, input ready);
  modport sink   (input valid, input accel_magnitude, output ready);
endinterface

interface afd_out_if import afd_pkg::*; ();
  logic valid;
  logic ready;
  logic fall_detected;
  mag_t impact_peak;
  logic armed;

  modport source (output valid, output fall_detected, output impact_peak, output armed,
                  input ready);
  modport sink   (input valid, input fall_detected, input impact_peak, input armed,
                  output ready);
endinterface

// ----- hdl/afd_regs.sv -----
// APB-style configuration registers: thresholds and sample windows.
// Depends on afd_pkg.
module afd_regs import afd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (wr_en) begin
      case (idx)
        REG_FF_THR:    cfg_q.ff_thr     <= pwdata[MagWidth-1:0];
        REG_IMP_THR:   cfg_q.imp_thr    <= pwdata[MagWidth-1:0];
        REG_FF_MIN:    cfg_q.ff_min     <= pwdata[WinWidth-1:0];
        REG_IMP_WIN:   cfg_q.imp_win    <= pwdata[WinWidth-1:0];
        REG_STILL_MIN: cfg_q.still_need <= pwdata[WinWidth-1:0];
        REG_POST_MAX:  cfg_q.post_lim   <= pwdata[WinWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FF_THR:    prdata = DataWidth'(cfg_q.ff_thr);
      REG_IMP_THR:   prdata = DataWidth'(cfg_q.imp_thr);
      REG_FF_MIN:    prdata = DataWidth'(cfg_q.ff_min);
      REG_IMP_WIN:   prdata = DataWidth'(cfg_q.imp_win);
      REG_STILL_MIN: prdata = DataWidth'(cfg_q.still_need);
      REG_POST_MAX:  prdata = DataWidth'(cfg_q.post_lim);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- hdl/afd_front.sv -----
// Front end: accepts samples and classifies them against the thresholds.
// Depends on afd_pkg and afd_in_if; feeds afd_queue.
module afd_front import afd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  afd_in_if.sink   in_s,
  input  cfg_t     cfg_i,
  input  logic     full_i,
  output logic     push_o,
  output sample_t  push_data_o
);

  logic    valid_q;
  sample_t data_q;
  sample_t data_d;
  mag_t    mag;

  assign mag = in_s.accel_magnitude;

  always_comb begin
    data_d.mag       = mag;
    data_d.below_ff  = mag < cfg_i.ff_thr;
    data_d.above_imp = mag > cfg_i.imp_thr;
    data_d.still     = (mag >= StillLo) && (mag <= StillHi);
  end

  assign in_s.ready  = !valid_q || !full_i;
  assign push_o      = valid_q && !full_i;
  assign push_data_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_s.ready) begin
      valid_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- hdl/afd_queue.sv -----
// Short queue of classified samples between the front end and the phase tracker.
// Depends on afd_pkg.
module afd_queue import afd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  sample_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output sample_t head_o
);

  sample_t             entry_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q;
  logic [PtrWidth-1:0] rd_ptr_q;
  logic [PtrWidth:0]   count_q;
  logic [PtrWidth:0]   count_d;

  assign full_o  = count_q == (PtrWidth+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/afd_back.sv -----
// Back end: phase tracker (normal, free-fall, wait impact, post impact) and
// the result register. Depends on afd_pkg and afd_out_if; fed by afd_queue.
module afd_back import afd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  sample_t   q_head_i,
  output logic      q_pop_o,
  afd_out_if.source out_m
);

  phase_e phase_q, phase_d;
  cnt_t   ff_cnt_q, ff_cnt_d;
  cnt_t   wait_cnt_q, wait_cnt_d;
  cnt_t   post_cnt_q, post_cnt_d;
  cnt_t   still_cnt_q, still_cnt_d;
  mag_t   peak_q, peak_d;

  logic   out_valid_q;
  logic   out_fall_q, out_fall_d;
  mag_t   out_peak_q, out_peak_d;
  logic   out_armed_q;

  cnt_t   wait_inc;
  cnt_t   post_inc;
  cnt_t   still_new;
  mag_t   peak_max;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_m.ready);

  assign wait_inc  = sat_inc(wait_cnt_q);
  assign post_inc  = sat_inc(post_cnt_q);
  assign still_new = q_head_i.still ? sat_inc(still_cnt_q) : '0;
  assign peak_max  = (q_head_i.mag > peak_q) ? q_head_i.mag : peak_q;

  always_comb begin
    phase_d     = phase_q;
    ff_cnt_d    = ff_cnt_q;
    wait_cnt_d  = wait_cnt_q;
    post_cnt_d  = post_cnt_q;
    still_cnt_d = still_cnt_q;
    peak_d      = peak_q;
    out_fall_d  = 1'b0;
    out_peak_d  = '0;
    case (phase_q)
      PH_NORMAL: begin
        if (q_head_i.below_ff) begin
          phase_d  = PH_FREEFALL;
          ff_cnt_d = cnt_t'(1);
        end
      end
      PH_FREEFALL: begin
        if (q_head_i.below_ff) begin
          ff_cnt_d = sat_inc(ff_cnt_q);
        end else if (ff_cnt_q >= cnt_t'(cfg_i.ff_min)) begin
          // the sample ending the free-fall may be the impact itself
          wait_cnt_d = '0;
          if (q_head_i.above_imp) begin
            phase_d     = PH_POST;
            peak_d      = q_head_i.mag;
            post_cnt_d  = '0;
            still_cnt_d = '0;
          end else begin
            phase_d = PH_WAIT;
            peak_d  = '0;
          end
        end else begin
          phase_d = PH_NORMAL;
        end
      end
      PH_WAIT: begin
        wait_cnt_d = wait_inc;
        if (q_head_i.above_imp) begin
          phase_d     = PH_POST;
          peak_d      = q_head_i.mag;
          post_cnt_d  = '0;
          still_cnt_d = '0;
        end else if (wait_inc > cnt_t'(cfg_i.imp_win)) begin
          phase_d = PH_NORMAL;
        end
      end
      PH_POST: begin
        post_cnt_d  = post_inc;
        still_cnt_d = still_new;
        peak_d      = peak_max;
        if (still_new >= cnt_t'(cfg_i.still_need) || post_inc > cnt_t'(cfg_i.post_lim)) begin
          if (still_new >= cnt_t'(cfg_i.still_need)) begin
            out_fall_d = 1'b1;
            out_peak_d = peak_max;
          end
          phase_d     = PH_NORMAL;
          ff_cnt_d    = '0;
          wait_cnt_d  = '0;
          post_cnt_d  = '0;
          still_cnt_d = '0;
          peak_d      = '0;
        end
      end
      default: begin
        phase_d = PH_NORMAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NORMAL;
      ff_cnt_q    <= '0;
      wait_cnt_q  <= '0;
      post_cnt_q  <= '0;
      still_cnt_q <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q     <= phase_d;
        ff_cnt_q    <= ff_cnt_d;
        wait_cnt_q  <= wait_cnt_d;
        post_cnt_q  <= post_cnt_d;
        still_cnt_q <= still_cnt_d;
        peak_q      <= peak_d;
        out_valid_q <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_fall_q  <= out_fall_d;
      out_peak_q  <= out_peak_d;
      out_armed_q <= phase_d != PH_NORMAL;
    end
  end

  assign out_m.valid         = out_valid_q;
  assign out_m.fall_detected = out_fall_q;
  assign out_m.impact_peak   = out_peak_q;
  assign out_m.armed         = out_armed_q;

endmodule

// ----- hdl/accel_fall_detector.sv -----
// Accelerometer fall detector, top level.
// Channels: in_s takes one acceleration magnitude per request (unsigned Q4.12 g,
// 1 g = 4096); out_m returns exactly one result per sample, in order:
// fall_detected, impact_peak (peak when a fall is confirmed, else 0) and armed.
// The APB port sets the two thresholds and four sample windows; pready is tied
// high and a write lands on the access cycle. Write only while no sample is in
// flight.
// Path: an accepted sample passes the front register, the queue and the result
// register before its result is valid. Throughput: one sample per cycle while the
// receiver keeps ready high; the phase tracker updates its counters once per sample.
// Stall: while the receiver holds ready low the result stays put, the queue
// and front register absorb three more samples, then in_s.ready drops.
// Reset: the detector returns to the normal phase with all counters and the
// peak cleared; registers take their default values. No clearing pass needed.
// Depends on afd_pkg, afd_if, afd_regs, afd_front, afd_queue, afd_back.
module accel_fall_detector import afd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  afd_in_if.sink               in_s,
  afd_out_if.source            out_m,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t    cfg;
  logic    push;
  sample_t push_data;
  logic    full;
  logic    pop;
  logic    q_valid;
  sample_t q_head;

  afd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  afd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_s),
    .cfg_i       (cfg),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  afd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  afd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (pop),
    .out_m     (out_m)
  );

endmodule

// ----- hdl/afd_checker.sv -----
// Port-level checks for the fall detector, bound to the top level.
// Depends on afd_pkg and accel_fall_detector.
module afd_checker import afd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic fall_detected,
  input mag_t impact_peak,
  input logic armed
);

  // peak is reported only with a confirmed fall
  a_peak_only_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !fall_detected |-> impact_peak == '0)
    else $error("impact_peak nonzero without fall");

  // a confirmed fall returns the detector to the normal phase
  a_fall_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && fall_detected |-> !armed)
    else $error("armed after confirmed fall");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(fall_detected)
      && $stable(impact_peak) && $stable(armed))
    else $error("result changed while stalled");

  // input only backs up behind a waiting result
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind accel_fall_detector afd_checker u_afd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (in_s.ready),
  .out_valid     (out_m.valid),
  .out_ready     (out_m.ready),
  .fall_detected (out_m.fall_detected),
  .impact_peak   (out_m.impact_peak),
  .armed         (out_m.armed)
);
